[sv/npe_pkg.sv]
// npe_pkg: shared widths and defaults for the next permutation engine.
// No dependencies; imported by npe_store and next_permutation_engine.
`default_nettype none

package npe_pkg;

    localparam int VAL_W       = 7;   // element value width
    localparam int MAX_LEN_DEF = 64;  // default longest permutation held

endpackage

`default_nettype wire

[sv/npe_store.sv]
// npe_store: element memory, one write port and one registered read port.
// Depends on npe_pkg for the element width.
`default_nettype none

module npe_store
    import npe_pkg::*;
#(
    parameter int DEPTH = MAX_LEN_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [VAL_W-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [VAL_W-1:0] o_rd_data
);

    logic [VAL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[sv/next_permutation_engine.sv]
// next_permutation_engine: lexicographic successor of a loaded permutation.
// Depends on npe_pkg and npe_store.
//
// Usage:
//   Input items (i_elem_value, i_last) are taken when start is high and busy
//   is low. Loading takes one item per cycle; busy stays low until the item
//   flagged last arrives, which fixes the length n (at most MAX_LEN; extra
//   elements are dropped, though their last flag still closes the sequence).
//   busy then stays high while one sequencer walks the element memory through
//   its single read port and single write port: a pivot search (S_PIV_RD,
//   S_PIV_CMP) from the right, a successor search (S_SUC_RD, S_SUC_CMP)
//   from the right, a swap (S_SWP_A, S_SWP_B), a reversal of the suffix
//   pair by pair (S_REV_RDA to S_REV_WRB) and output (S_OUT_RD, S_OUT).
//   Results appear on o_out_value/o_exists/o_out_last for one cycle each,
//   marked by o_valid; the last one carries o_out_last. With no successor a
//   single result with o_exists low and o_out_value zero is given.
//   The receiver cannot stall. Reset (synchronous, active low) returns the
//   sequencer to idle and empties the element count; memory is not cleared.
`default_nettype none

module next_permutation_engine
    import npe_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [VAL_W-1:0] i_elem_value,
    input  wire logic             i_last,
    output logic                  o_valid,
    output logic      [VAL_W-1:0] o_out_value,
    output logic                  o_exists,
    output logic                  o_out_last
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_PIV_RD  = 13'b0000000000010,
        S_PIV_CMP = 13'b0000000000100,
        S_SUC_RD  = 13'b0000000001000,
        S_SUC_CMP = 13'b0000000010000,
        S_SWP_A   = 13'b0000000100000,
        S_SWP_B   = 13'b0000001000000,
        S_REV_RDA = 13'b0000010000000,
        S_REV_RDB = 13'b0000100000000,
        S_REV_WRA = 13'b0001000000000,
        S_REV_WRB = 13'b0010000000000,
        S_OUT_RD  = 13'b0100000000000,
        S_OUT     = 13'b1000000000000
    } t_state;

    t_state           r_state, n_state;
    logic             r_none,  n_none;
    logic [CW-1:0]    r_cnt,   n_cnt;
    logic [AW-1:0]    r_top,   n_top;
    logic [AW-1:0]    r_idx,   n_idx;
    logic [AW-1:0]    r_piv,   n_piv;
    logic [AW-1:0]    r_lo,    n_lo;
    logic [AW-1:0]    r_hi,    n_hi;
    logic [VAL_W-1:0] r_prev,  n_prev;
    logic [VAL_W-1:0] r_pval,  n_pval;
    logic [VAL_W-1:0] r_tmp,   n_tmp;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic [AW-1:0]    rd_addr;
    logic [VAL_W-1:0] rd_data;

    logic             room;
    logic [CW-1:0]    n_len;
    logic [AW-1:0]    lo_inc;
    logic [AW-1:0]    hi_dec;

    npe_store #(
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign room   = (r_cnt < CW'(MAX_LEN));
    assign n_len  = room ? CW'(r_cnt + 1'b1) : r_cnt;
    assign lo_inc = AW'(r_lo + 1'b1);
    assign hi_dec = AW'(r_hi - 1'b1);

    always_comb begin
        n_state = r_state;
        n_none  = 1'b0;
        n_cnt   = r_cnt;
        n_top   = r_top;
        n_idx   = r_idx;
        n_piv   = r_piv;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_prev  = r_prev;
        n_pval  = r_pval;
        n_tmp   = r_tmp;
        wr_en   = 1'b0;
        wr_addr = r_lo;
        wr_data = rd_data;
        rd_addr = r_idx;

        if (r_none) begin
            // single no-successor result takes this cycle
            n_state = S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        wr_en   = room;
                        wr_addr = r_cnt[AW-1:0];
                        wr_data = i_elem_value;
                        n_cnt   = n_len;
                        if (i_last) begin
                            n_cnt = '0;
                            n_top = AW'(n_len - 1'b1);
                            n_idx = AW'(n_len - 1'b1);
                            if (n_len < CW'(2)) begin
                                n_none = 1'b1;
                            end else begin
                                n_state = S_PIV_RD;
                            end
                        end
                    end
                end
                S_PIV_RD: begin
                    n_state = S_PIV_CMP;
                end
                S_PIV_CMP: begin
                    if ((r_idx != r_top) && (rd_data < r_prev)) begin
                        n_piv   = r_idx;
                        n_pval  = rd_data;
                        n_idx   = r_top;
                        n_state = S_SUC_RD;
                    end else begin
                        n_prev = rd_data;
                        if (r_idx == '0) begin
                            n_none  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_idx   = AW'(r_idx - 1'b1);
                            n_state = S_PIV_RD;
                        end
                    end
                end
                S_SUC_RD: begin
                    n_state = S_SUC_CMP;
                end
                S_SUC_CMP: begin
                    // the element right of the pivot always qualifies
                    if (rd_data > r_pval) begin
                        n_tmp   = rd_data;
                        n_state = S_SWP_A;
                    end else begin
                        n_idx   = AW'(r_idx - 1'b1);
                        n_state = S_SUC_RD;
                    end
                end
                S_SWP_A: begin
                    wr_en   = 1'b1;
                    wr_addr = r_piv;
                    wr_data = r_tmp;
                    n_state = S_SWP_B;
                end
                S_SWP_B: begin
                    wr_en   = 1'b1;
                    wr_addr = r_idx;
                    wr_data = r_pval;
                    n_lo    = AW'(r_piv + 1'b1);
                    n_hi    = r_top;
                    n_idx   = '0;
                    n_state = (AW'(r_piv + 1'b1) < r_top) ? S_REV_RDA : S_OUT_RD;
                end
                S_REV_RDA: begin
                    rd_addr = r_lo;
                    n_state = S_REV_RDB;
                end
                S_REV_RDB: begin
                    rd_addr = r_hi;
                    n_tmp   = rd_data;
                    n_state = S_REV_WRA;
                end
                S_REV_WRA: begin
                    wr_en   = 1'b1;
                    wr_addr = r_lo;
                    wr_data = rd_data;
                    n_state = S_REV_WRB;
                end
                S_REV_WRB: begin
                    wr_en   = 1'b1;
                    wr_addr = r_hi;
                    wr_data = r_tmp;
                    n_lo    = lo_inc;
                    n_hi    = hi_dec;
                    n_state = (lo_inc < hi_dec) ? S_REV_RDA : S_OUT_RD;
                end
                S_OUT_RD: begin
                    n_state = S_OUT;
                end
                S_OUT: begin
                    if (r_idx == r_top) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = AW'(r_idx + 1'b1);
                        n_state = S_OUT_RD;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_none  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_none  <= n_none;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top  <= n_top;
        r_idx  <= n_idx;
        r_piv  <= n_piv;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_prev <= n_prev;
        r_pval <= n_pval;
        r_tmp  <= n_tmp;
    end

    assign busy        = (r_state != S_IDLE) || r_none;
    assign o_valid     = (r_state == S_OUT) || r_none;
    assign o_out_value = r_none ? '0 : rd_data;
    assign o_exists    = !r_none;
    assign o_out_last  = r_none || (r_idx == r_top);

    a_valid_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while idle");

    a_none_shape : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_exists) |-> (o_out_last && (o_out_value == '0)))
        else $error("no-successor result malformed");

    a_last_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_last) |=> !busy)
        else $error("block not idle after final result");

    a_load_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last) |=> (!o_valid && !busy))
        else $error("unexpected result or busy during loading");

endmodule

`default_nettype wire

[bench/tb_top.sv]
// tb_top: self-checking bench for next_permutation_engine.
// Drives element items through start/busy, predicts each lexicographic successor and
// checks every strobed result in order. Depends on npe_pkg and the engine RTL.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import npe_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 80;
    localparam int SEQ_MAX      = 70;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             exists;
        logic             last;
    } succ_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
        logic             typed;  // result written in below rather than predicted
        succ_item_t       want;
    } stim_row_t;

    localparam succ_item_t NO_SUCC = '{value: '0, exists: 1'b0, last: 1'b1};
    localparam succ_item_t UNUSED  = '0;

    localparam int N_DIRECTED = 21;
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{7'd1,   1'b1, 1'b1, NO_SUCC},   // single element
        '{7'd3,   1'b0, 1'b0, UNUSED},    // descending: no successor
        '{7'd2,   1'b0, 1'b0, UNUSED},
        '{7'd1,   1'b1, 1'b1, NO_SUCC},
        '{7'd2,   1'b0, 1'b0, UNUSED},    // pivot at the first position
        '{7'd3,   1'b0, 1'b0, UNUSED},
        '{7'd1,   1'b1, 1'b0, UNUSED},
        '{7'd1,   1'b0, 1'b0, UNUSED},    // ascending pair
        '{7'd2,   1'b1, 1'b0, UNUSED},
        '{7'd0,   1'b0, 1'b0, UNUSED},    // field extremes, not a valid permutation
        '{7'd127, 1'b1, 1'b0, UNUSED},
        '{7'd2,   1'b0, 1'b0, UNUSED},    // all equal: no successor
        '{7'd2,   1'b0, 1'b0, UNUSED},
        '{7'd2,   1'b1, 1'b1, NO_SUCC},
        '{7'd1,   1'b0, 1'b0, UNUSED},    // duplicates with a successor
        '{7'd2,   1'b0, 1'b0, UNUSED},
        '{7'd2,   1'b1, 1'b0, UNUSED},
        '{7'd1,   1'b0, 1'b0, UNUSED},    // long suffix to reverse
        '{7'd4,   1'b0, 1'b0, UNUSED},
        '{7'd3,   1'b0, 1'b0, UNUSED},
        '{7'd2,   1'b1, 1'b0, UNUSED}
    };

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             start        = 1'b0;
    logic [VAL_W-1:0] i_elem_value = '0;
    logic             i_last       = 1'b0;
    logic             busy;
    logic             o_valid;
    logic [VAL_W-1:0] o_out_value;
    logic             o_exists;
    logic             o_out_last;

    next_permutation_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_elem_value (i_elem_value),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .o_out_value  (o_out_value),
        .o_exists     (o_exists),
        .o_out_last   (o_out_last)
    );

    always #5ns i_clk = ~i_clk;

    // predictor state
    logic [VAL_W-1:0] perm_held [MAX_LEN_DEF];
    int               held_count = 0;
    succ_item_t       succ_q [$];

    int  errors       = 0;
    int  quiet_cycles = 0;
    int  items_sent   = 0;
    bit  no_idle      = 1'b0;

    // Stores one element; on the last one works out the successor of what is held.
    task automatic absorb_element(input logic [VAL_W-1:0] v, input logic l, input bit keep);
        int  n;
        int  piv;
        int  i;
        int  j;
        int  lo;
        int  hi;
        bit  found;
        logic [VAL_W-1:0] t;
        if (held_count < MAX_LEN_DEF) begin
            perm_held[held_count] = v;
            held_count++;
        end
        if (!l)
            return;
        n = held_count;
        held_count = 0;
        found = 1'b0;
        piv = 0;
        for (i = n - 1; i > 0; i--) begin
            if (!found && perm_held[i-1] < perm_held[i]) begin
                piv = i - 1;
                found = 1'b1;
            end
        end
        if (!found) begin
            if (keep)
                succ_q.push_back(NO_SUCC);
            return;
        end
        j = n - 1;
        while (j > piv && perm_held[j] <= perm_held[piv])
            j--;
        t = perm_held[piv];
        perm_held[piv] = perm_held[j];
        perm_held[j] = t;
        lo = piv + 1;
        hi = n - 1;
        while (lo < hi) begin
            t = perm_held[lo];
            perm_held[lo] = perm_held[hi];
            perm_held[hi] = t;
            lo++;
            hi--;
        end
        if (keep)
            for (i = 0; i < n; i++)
                succ_q.push_back('{value: perm_held[i], exists: 1'b1, last: (i == n - 1)});
    endtask

    task automatic send_elem(input logic [VAL_W-1:0] v, input logic l, input bit keep);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        repeat (gap) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_elem_value <= v;
        i_last       <= l;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        items_sent++;
        absorb_element(v, l, keep);
    endtask

    // Well-formed sequences are shuffles of 1..len; noisy ones take any field value.
    task automatic send_sequence(input int len, input bit noisy);
        logic [VAL_W-1:0] seq [SEQ_MAX];
        logic [VAL_W-1:0] t;
        int k;
        int r;
        for (k = 0; k < len; k++)
            seq[k] = noisy ? VAL_W'($urandom_range(0, 127)) : VAL_W'(k + 1);
        for (k = len - 1; k > 0; k--) begin
            r = $urandom_range(0, k);
            t = seq[k];
            seq[k] = seq[r];
            seq[r] = t;
        end
        no_idle = ($urandom_range(0, 3) == 0);
        for (k = 0; k < len; k++)
            send_elem(seq[k], k == len - 1, 1'b1);
    endtask

    always @(posedge i_clk) begin : check_results
        succ_item_t want;
        if (i_rst_n && o_valid) begin
            if (succ_q.size() == 0) begin
                $display("%0t: unexpected result value %0d exists %0b last %0b",
                         $time, o_out_value, o_exists, o_out_last);
                errors++;
            end else begin
                want = succ_q.pop_front();
                if (o_out_value !== want.value) begin
                    $display("%0t: out_value expected %0d actual %0d",
                             $time, want.value, o_out_value);
                    errors++;
                end
                if (o_exists !== want.exists) begin
                    $display("%0t: exists expected %0b actual %0b",
                             $time, want.exists, o_exists);
                    errors++;
                end
                if (o_out_last !== want.last) begin
                    $display("%0t: out_last expected %0b actual %0b",
                             $time, want.last, o_out_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, succ_q.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int row;
        int random_sent;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < N_DIRECTED; row++) begin
            no_idle = (row >= 14);
            send_elem(DIRECTED[row].value, DIRECTED[row].last, !DIRECTED[row].typed);
            if (DIRECTED[row].typed)
                succ_q.push_back(DIRECTED[row].want);
        end

        random_sent = items_sent;
        while (items_sent - random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0)
                send_sequence($urandom_range(1, 20), 1'b1);
            else if ($urandom_range(0, 9) == 0)
                send_sequence($urandom_range(11, 20), 1'b0);
            else
                send_sequence($urandom_range(1, 10), 1'b0);
        end
        // overlong: the last flag falls on a dropped element, a full store is used
        send_sequence(MAX_LEN_DEF + 1, 1'b0);

        start <= 1'b0;
        while (succ_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (succ_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, succ_q.size());
            errors++;
        end
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
